// ===== rtl/core/ihps_pkg.sv =====
// shared types and constants of the infohash peer store
package ihps_pkg;

  localparam int MAX_HASHES_DEF = 64;
  localparam int MAX_PEERS_DEF  = 8;

  localparam logic [15:0] WINDOW_RESET = 16'd1920;

  localparam logic [1:0] FAM_V4 = 2'd0;
  localparam logic [1:0] FAM_V6 = 2'd1;

  typedef struct packed {
    logic [31:0] hi;
    logic [63:0] mid;
    logic [63:0] lo;
  } key_t;

  typedef struct packed {
    logic        is_v6;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [15:0] port;
    logic [31:0] seen;
  } slot_t;

  typedef enum logic [2:0] {
    ST_REFRESHED = 3'd0,
    ST_ADDED     = 3'd1,
    ST_FULL      = 3'd2,
    ST_REJECTED  = 3'd3,
    ST_EXPIRED   = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH,
    S_DECIDE,
    S_SEEK,
    S_SRD,
    S_SCMP,
    S_SEND,
    S_EHEAD,
    S_ERD,
    S_ECHK,
    S_EMOVE,
    S_EDONE,
    S_ESTEP,
    S_OUT
  } state_t;

endpackage

// ===== rtl/core/infohash_peer_store_unit.sv =====
// top level of the infohash peer store: entry ring, slot memory and sequencer
//
// Requests enter on in_valid/in_ready and are taken only while the sequencer
// is idle; each request gives one result on out_valid/out_ready, held in an
// output register so the next request may be taken while a result waits.
// The entries sit in a ring of cells that rotates one place a cycle while
// the sequencer steps it; the sequencer works on the cell at the head and
// on the peer slot memory. A store request rotates the ring a full turn to
// look up the infohash, rotates on until the entry is at the head, then
// reads its slots one at a time. A rejected family goes straight to the
// result. An expire request visits every entry; for a held one it checks
// each peer and moves the last peer into the slot of each removed one. The
// slot memory's single read port bounds the peer walk to one read a cycle.
// cfg_write loads window from cfg_data; write it only while idle.
// Reset clears all valid flags, peer counts and the entry count at once and
// sets window to 1920. A stalled receiver holds the result in place
// and a finished request waits until the output register is free.
module infohash_peer_store_unit #(
  parameter int MAX_HASHES = ihps_pkg::MAX_HASHES_DEF,
  parameter int MAX_PEERS  = ihps_pkg::MAX_PEERS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [31:0] hash_hi,
  input  logic [63:0] hash_mid,
  input  logic [63:0] hash_lo,
  input  logic [1:0]  addr_family,
  input  logic [63:0] addr_hi,
  input  logic [63:0] addr_lo,
  input  logic [15:0] peer_port,
  input  logic [31:0] now_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [6:0]  hashes_in_use,
  output logic [3:0]  peers_in_entry,
  output logic [9:0]  expired_peers
);

  localparam int HW    = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;
  localparam int CW    = $clog2(MAX_PEERS + 1);
  localparam int TW    = $clog2(MAX_HASHES + 1);
  localparam int DEPTH = MAX_HASHES * MAX_PEERS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW    = $clog2(DEPTH + 1);

  localparam logic [HW-1:0] LAST_IDX = HW'(MAX_HASHES - 1);
  localparam logic [CW-1:0] PEERS_N  = CW'(MAX_PEERS);

  ihps_pkg::state_t state, state_next;

  logic [15:0]    window;
  ihps_pkg::key_t req_key;
  logic           req_v6;
  logic [63:0]    req_ahi;
  logic [63:0]    req_alo;
  logic [15:0]    req_port;
  logic [31:0]    req_now;
  logic           active;
  logic [31:0]    limit;

  logic [HW-1:0]  rot;
  logic [HW-1:0]  step;
  logic           found_ok;
  logic [HW-1:0]  found_idx;
  logic           free_ok;
  logic [HW-1:0]  free_idx;
  logic [HW-1:0]  target;
  logic           is_new;
  logic [CW-1:0]  n;
  logic [CW-1:0]  i;
  logic [TW-1:0]  total;
  logic [RW-1:0]  removed;
  ihps_pkg::status_t res_status;
  logic [CW-1:0]  res_peers;

  logic             cell_v [MAX_HASHES];
  ihps_pkg::key_t   cell_k [MAX_HASHES];
  logic [CW-1:0]    cell_c [MAX_HASHES];

  logic             rotate;
  logic             load;
  logic             ld_v;
  ihps_pkg::key_t   ld_k;
  logic [CW-1:0]    ld_c;

  ihps_pkg::slot_t  mem [DEPTH];
  ihps_pkg::slot_t  rdata;
  ihps_pkg::slot_t  wdata;
  logic             mem_re;
  logic             mem_we;
  logic [AW-1:0]    raddr;
  logic [AW-1:0]    waddr;
  logic [AW-1:0]    base;

  logic head_hit;
  logic slot_hit;
  logic out_free;

  // entry ring
  for (genvar g = 0; g < MAX_HASHES; g++) begin : g_ring
    if (g == 0) begin : g_head
      ihps_cell #(.CW(CW)) u_cell (
        .clk  (clk),
        .rst  (rst),
        .en   (rotate | load),
        .vin  (load ? ld_v : cell_v[MAX_HASHES-1]),
        .kin  (load ? ld_k : cell_k[MAX_HASHES-1]),
        .cin  (load ? ld_c : cell_c[MAX_HASHES-1]),
        .vout (cell_v[0]),
        .kout (cell_k[0]),
        .cout (cell_c[0])
      );
    end else begin : g_body
      ihps_cell #(.CW(CW)) u_cell (
        .clk  (clk),
        .rst  (rst),
        .en   (rotate),
        .vin  (cell_v[g-1]),
        .kin  (cell_k[g-1]),
        .cin  (cell_c[g-1]),
        .vout (cell_v[g]),
        .kout (cell_k[g]),
        .cout (cell_c[g])
      );
    end
  end

  assign head_hit = cell_v[0] && (cell_k[0] == req_key);
  assign slot_hit = (rdata.port == req_port) && (rdata.is_v6 == req_v6) &&
                    (rdata.addr_hi == req_ahi) && (rdata.addr_lo == req_alo);
  assign base     = AW'(rot) * AW'(MAX_PEERS);
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ihps_pkg::S_IDLE);

  // slot memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ihps_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rotate     = 1'b0;
    load       = 1'b0;
    ld_v       = 1'b0;
    ld_k       = cell_k[0];
    ld_c       = n;
    mem_re     = 1'b0;
    mem_we     = 1'b0;
    raddr      = base + AW'(i);
    waddr      = base + AW'(i);
    wdata      = rdata;
    case (state)
      ihps_pkg::S_IDLE: begin
        if (in_valid) begin
          if (func) begin
            state_next = ihps_pkg::S_EHEAD;
          end else if (!(addr_family inside {ihps_pkg::FAM_V4, ihps_pkg::FAM_V6})) begin
            state_next = ihps_pkg::S_OUT;
          end else begin
            state_next = ihps_pkg::S_SEARCH;
          end
        end
      end
      ihps_pkg::S_SEARCH: begin
        rotate = 1'b1;
        if (step == LAST_IDX) begin
          state_next = ihps_pkg::S_DECIDE;
        end
      end
      ihps_pkg::S_DECIDE: begin
        if (!found_ok && !free_ok) begin
          state_next = ihps_pkg::S_OUT;
        end else begin
          state_next = ihps_pkg::S_SEEK;
        end
      end
      ihps_pkg::S_SEEK: begin
        if (rot == target) begin
          state_next = ihps_pkg::S_SRD;
        end else begin
          rotate = 1'b1;
        end
      end
      ihps_pkg::S_SRD: begin
        if (i < n) begin
          mem_re     = 1'b1;
          state_next = ihps_pkg::S_SCMP;
        end else begin
          state_next = ihps_pkg::S_SEND;
        end
      end
      ihps_pkg::S_SCMP: begin
        if (slot_hit) begin
          mem_we     = 1'b1;
          wdata      = rdata;
          wdata.seen = req_now;
          state_next = ihps_pkg::S_OUT;
        end else begin
          state_next = ihps_pkg::S_SRD;
        end
      end
      ihps_pkg::S_SEND: begin
        if (n < PEERS_N) begin
          mem_we        = 1'b1;
          waddr         = base + AW'(n);
          wdata.is_v6   = req_v6;
          wdata.addr_hi = req_ahi;
          wdata.addr_lo = req_alo;
          wdata.port    = req_port;
          wdata.seen    = req_now;
          load          = 1'b1;
          ld_v          = 1'b1;
          ld_k          = req_key;
          ld_c          = n + CW'(1);
        end
        state_next = ihps_pkg::S_OUT;
      end
      ihps_pkg::S_EHEAD: begin
        if (cell_v[0]) begin
          state_next = ihps_pkg::S_ERD;
        end else begin
          rotate = 1'b1;
          if (step == LAST_IDX) begin
            state_next = ihps_pkg::S_OUT;
          end
        end
      end
      ihps_pkg::S_ERD: begin
        if (active && (i < n)) begin
          mem_re     = 1'b1;
          state_next = ihps_pkg::S_ECHK;
        end else begin
          state_next = ihps_pkg::S_EDONE;
        end
      end
      ihps_pkg::S_ECHK: begin
        if ((rdata.seen < limit) && (i != n - CW'(1))) begin
          mem_re     = 1'b1;
          raddr      = base + AW'(n - CW'(1));
          state_next = ihps_pkg::S_EMOVE;
        end else begin
          state_next = ihps_pkg::S_ERD;
        end
      end
      ihps_pkg::S_EMOVE: begin
        mem_we     = 1'b1;
        wdata      = rdata;
        state_next = ihps_pkg::S_ERD;
      end
      ihps_pkg::S_EDONE: begin
        load       = 1'b1;
        ld_v       = (n != '0);
        ld_k       = cell_k[0];
        ld_c       = n;
        state_next = ihps_pkg::S_ESTEP;
      end
      ihps_pkg::S_ESTEP: begin
        rotate = 1'b1;
        if (step == LAST_IDX) begin
          state_next = ihps_pkg::S_OUT;
        end else begin
          state_next = ihps_pkg::S_EHEAD;
        end
      end
      ihps_pkg::S_OUT: begin
        if (out_free) begin
          state_next = ihps_pkg::S_IDLE;
        end
      end
      default: state_next = ihps_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= ihps_pkg::WINDOW_RESET;
    end else if (cfg_write) begin
      window <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rot <= '0;
    end else if (rotate) begin
      rot <= (rot == LAST_IDX) ? '0 : rot + HW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ihps_pkg::S_OUT) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total     <= '0;
      step      <= '0;
      found_ok  <= 1'b0;
      free_ok   <= 1'b0;
      removed   <= '0;
    end else begin
      case (state)
        ihps_pkg::S_IDLE: begin
          if (in_valid) begin
            req_key  <= '{hi: hash_hi, mid: hash_mid, lo: hash_lo};
            req_v6   <= (addr_family == ihps_pkg::FAM_V6);
            req_ahi  <= (addr_family == ihps_pkg::FAM_V6) ? addr_hi : 64'd0;
            req_alo  <= (addr_family == ihps_pkg::FAM_V6) ? addr_lo :
                        {32'd0, addr_lo[31:0]};
            req_port <= peer_port;
            req_now  <= now_time;
            active   <= (now_time >= {16'd0, window});
            limit    <= now_time - {16'd0, window};
            found_ok <= 1'b0;
            free_ok  <= 1'b0;
            step     <= '0;
            i        <= '0;
            removed  <= '0;
            res_peers <= '0;
            res_status <= func ? ihps_pkg::ST_EXPIRED : ihps_pkg::ST_REJECTED;
          end
        end
        ihps_pkg::S_SEARCH: begin
          if (head_hit && !found_ok) begin
            found_ok  <= 1'b1;
            found_idx <= rot;
          end
          if (!cell_v[0] && (!free_ok || (rot < free_idx))) begin
            free_ok  <= 1'b1;
            free_idx <= rot;
          end
          step <= (step == LAST_IDX) ? '0 : step + HW'(1);
        end
        ihps_pkg::S_DECIDE: begin
          target <= found_ok ? found_idx : free_idx;
          is_new <= !found_ok;
        end
        ihps_pkg::S_SEEK: begin
          if (rot == target) begin
            n <= is_new ? '0 : cell_c[0];
            i <= '0;
          end
        end
        ihps_pkg::S_SCMP: begin
          if (slot_hit) begin
            res_status <= ihps_pkg::ST_REFRESHED;
            res_peers  <= n;
          end else begin
            i <= i + CW'(1);
          end
        end
        ihps_pkg::S_SEND: begin
          if (n < PEERS_N) begin
            res_status <= ihps_pkg::ST_ADDED;
            res_peers  <= n + CW'(1);
            if (is_new) begin
              total <= total + TW'(1);
            end
          end else begin
            res_status <= ihps_pkg::ST_FULL;
            res_peers  <= n;
          end
        end
        ihps_pkg::S_EHEAD: begin
          if (cell_v[0]) begin
            n <= cell_c[0];
            i <= '0;
          end else begin
            step <= (step == LAST_IDX) ? '0 : step + HW'(1);
          end
        end
        ihps_pkg::S_ECHK: begin
          if (rdata.seen < limit) begin
            n       <= n - CW'(1);
            removed <= removed + RW'(1);
          end else begin
            i <= i + CW'(1);
          end
        end
        ihps_pkg::S_EDONE: begin
          if ((n == '0) && (total != '0)) begin
            total <= total - TW'(1);
          end
        end
        ihps_pkg::S_ESTEP: begin
          step <= (step == LAST_IDX) ? '0 : step + HW'(1);
        end
        ihps_pkg::S_OUT: begin
          if (out_free) begin
            status         <= res_status;
            hashes_in_use  <= 7'(total);
            peers_in_entry <= 4'(res_peers);
            expired_peers  <= 10'(removed);
          end
        end
        default: ;
      endcase
    end
  end

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= TW'(MAX_HASHES))
    else $error("entry count above table size");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while busy");

  a_peers_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (peers_in_entry <= 4'(MAX_PEERS)))
    else $error("peer count above slot limit");

  a_ring_parked: assert property (@(posedge clk) disable iff (rst)
    (state == ihps_pkg::S_IDLE) |-> (step == '0))
    else $error("walk step left running");

endmodule

// ===== rtl/core/ihps_cell.sv =====
// one cell of the entry ring: valid flag, infohash key and peer count
module ihps_cell #(
  parameter int CW = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             vin,
  input  ihps_pkg::key_t   kin,
  input  logic [CW-1:0]    cin,
  output logic             vout,
  output ihps_pkg::key_t   kout,
  output logic [CW-1:0]    cout
);

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
      cout <= '0;
    end else if (en) begin
      vout <= vin;
      cout <= cin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kout <= kin;
    end
  end

endmodule
